// ===== sv/assert_macros.svh =====
// assertion helpers for the hash table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define CHK_IMPL(lbl, clk_i, rst_ni, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication checked outside reset
`define CHK_NEXT(lbl, clk_i, rst_ni, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== sv/mdht_pkg.sv =====
// ----------------------------------------------------------------------------
// mdht_pkg
// status codes and shared types of the multilevel hash table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mdht_pkg;
  localparam logic [3:0] ST_INSERTED   = 4'd0;
  localparam logic [3:0] ST_DUPLICATE  = 4'd1;
  localparam logic [3:0] ST_FOUND      = 4'd2;
  localparam logic [3:0] ST_ABSENT     = 4'd3;
  localparam logic [3:0] ST_BAD_SEQ    = 4'd4;
  localparam logic [3:0] ST_ZERO_KEY   = 4'd5;
  localparam logic [3:0] ST_REASSIGNED = 4'd6;
  localparam logic [3:0] ST_LEVEL_FULL = 4'd7;
  localparam logic [3:0] ST_CAPACITY   = 4'd8;
  localparam logic [3:0] ST_FAILED     = 4'd9;

  localparam int unsigned FILL_NUM = 7;
  localparam int unsigned FILL_DEN = 10;

  typedef struct packed {
    logic [255:0] key;
    logic [62:0]  seq;
    logic [63:0]  pay;
  } slot_t;
endpackage

// ===== sv/mdht_ram.sv =====
// ----------------------------------------------------------------------------
// mdht_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mdht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== sv/multilevel_double_hash_table.sv =====
// ----------------------------------------------------------------------------
// multilevel_double_hash_table
// cascade of open-addressed levels probed by double hashing
// ----------------------------------------------------------------------------
// channel  direction  handshake
// in_      input      in_valid / in_stall
// out_     output     out_valid / out_stall
// cfg_     input      cfg_valid / cfg_ready
// each probe sets the ram address, then takes the registered read; an item
// takes one probe per slot visited, plus a write state on insert
// zero key, failed and bad sequence beats go straight from idle to the done state
// after reset a clearing pass writes every slot with in_stall high
// a new beat is taken while a result waits in the output register
// a stalled result holds the block in its done state with in_stall high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module multilevel_double_hash_table #(
  parameter int LEVELS     = 3,
  parameter int BASE_POWER = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [63:0] in_key_word0,
  input  logic [63:0] in_key_word1,
  input  logic [63:0] in_key_word2,
  input  logic [63:0] in_key_word3,
  input  logic [62:0] in_sequence_req,
  input  logic [63:0] in_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [62:0] out_found_sequence,
  output logic [63:0] out_found_payload,
  output logic [2:0]  out_level,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [62:0] cfg_visible_sequence_limit
);
  localparam int TOTAL = ((((1 << (2 * LEVELS)) - 1) / 3) << BASE_POWER);
  localparam int AW    = $clog2(TOTAL);
  localparam int MAXP  = BASE_POWER + 2 * (LEVELS - 1);
  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW    = MAXP + 1;
  localparam int SW    = $bits(mdht_pkg::slot_t);

  typedef enum logic [5:0] {
    S_CLR   = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ADDR  = 6'b000100,
    S_READ  = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [255:0] key_r;
  logic [62:0] seq_r;
  logic [63:0] pay_r;
  logic op_r;
  logic [LW-1:0] lv_r, lv_nxt;
  logic [MAXP-1:0] pos_r, pos_nxt;
  logic [MAXP:0] n_r, n_nxt;
  logic [AW-1:0] at_r, at_nxt;
  logic [CW-1:0] cnt_r [LEVELS];
  logic [LEVELS-1:0] sealed_r;
  logic failed_r;
  logic [62:0] limit_r;
  logic ov_r;
  logic [3:0] st_r;
  logic [62:0] fs_r;
  logic [63:0] fp_r;
  logic [2:0] fl_r;
  logic [3:0] pst_r;
  logic [62:0] pfs_r;
  logic [63:0] pfp_r;
  logic [2:0] pfl_r;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  mdht_pkg::slot_t ram_wd, ram_rd;

  mdht_ram #(.WIDTH(SW), .DEPTH(TOTAL)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  function automatic logic [MAXP-1:0] lmask(input logic [LW-1:0] lv);
    logic [MAXP-1:0] m;
    m = '0;
    for (int i = 0; i < LEVELS; i++)
      if (lv == LW'(i)) m = MAXP'((64'd1 << (BASE_POWER + 2 * i)) - 64'd1);
    return m;
  endfunction

  function automatic logic [AW-1:0] lbase(input logic [LW-1:0] lv);
    logic [AW-1:0] b;
    b = '0;
    for (int i = 0; i < LEVELS; i++)
      if (lv == LW'(i)) b = AW'(((((1 << (2 * i)) - 1) / 3) << BASE_POWER));
    return b;
  endfunction

  function automatic logic [CW-1:0] lthr(input logic [LW-1:0] lv);
    logic [CW-1:0] t;
    t = '0;
    for (int i = 0; i < LEVELS; i++)
      if (lv == LW'(i))
        t = CW'(((64'd1 << (BASE_POWER + 2 * i)) * mdht_pkg::FILL_NUM)
                / mdht_pkg::FILL_DEN);
    return t;
  endfunction

  logic [MAXP-1:0] hstart, hstep, mk;
  assign hstart = MAXP'({key_r[71:64], key_r[63:8]});
  assign hstep  = MAXP'({key_r[135:128], key_r[127:72]}) | MAXP'(1);
  assign mk = lmask(lv_r);

  logic hit_empty, hit_match, last_lv, out_free, key_zero;
  assign hit_empty = (ram_rd.key == '0);
  assign hit_match = (ram_rd.key == key_r);
  assign last_lv = (lv_r == LW'(LEVELS - 1));
  assign out_free = !ov_r || !out_stall;
  assign key_zero = ({in_key_word3, in_key_word2, in_key_word1, in_key_word0} == '0);

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_found_sequence = fs_r;
  assign out_found_payload = fp_r;
  assign out_level = fl_r;

  logic [3:0] rst_st;
  logic [62:0] rfs;
  logic [63:0] rfp;
  logic [2:0] rfl;
  logic set_fail, bump, res_ld;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    lv_nxt = lv_r;
    pos_nxt = pos_r;
    n_nxt = n_r;
    at_nxt = at_r;
    ram_we = 1'b0;
    ram_addr = at_r;
    ram_wd = '{key: key_r, seq: seq_r, pay: pay_r};
    rst_st = st_r;
    rfs = '0;
    rfp = '0;
    rfl = '0;
    set_fail = 1'b0;
    bump = 1'b0;
    res_ld = 1'b0;
    case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        ram_addr = clr_r;
        ram_wd = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(TOTAL - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: ;
      S_ADDR: begin
        at_nxt = lbase(lv_r) + AW'(pos_r & mk);
        ram_addr = at_nxt;
        state_nxt = S_READ;
      end
      S_READ: begin
        if (hit_empty || hit_match) begin
          if (op_r) begin
            if (hit_match) begin
              res_ld = 1'b1;
              if (ram_rd.seq > limit_r) rst_st = mdht_pkg::ST_ABSENT;
              else begin
                rst_st = mdht_pkg::ST_FOUND;
                rfs = ram_rd.seq;
                rfp = ram_rd.pay;
                rfl = 3'(lv_r);
              end
            end else if (!sealed_r[lv_r] || last_lv) begin
              res_ld = 1'b1;
              rst_st = mdht_pkg::ST_ABSENT;
            end
          end else begin
            if (hit_match) begin
              res_ld = 1'b1;
              if (ram_rd.seq == seq_r && ram_rd.pay == pay_r) begin
                rst_st = mdht_pkg::ST_DUPLICATE;
                rfl = 3'(lv_r);
              end else begin
                rst_st = mdht_pkg::ST_REASSIGNED;
                set_fail = 1'b1;
              end
            end else if (!sealed_r[lv_r]) begin
              state_nxt = S_WRITE;
            end else if (last_lv) begin
              res_ld = 1'b1;
              rst_st = mdht_pkg::ST_CAPACITY;
              set_fail = 1'b1;
            end
          end
          if (!res_ld && state_nxt != S_WRITE) begin
            lv_nxt = lv_r + LW'(1);
            pos_nxt = hstart;
            n_nxt = '0;
            state_nxt = S_ADDR;
          end
        end else if ((n_r & (MAXP+1)'(mk)) == (MAXP+1)'(mk)) begin
          res_ld = 1'b1;
          rst_st = mdht_pkg::ST_LEVEL_FULL;
          set_fail = !op_r;
        end else begin
          n_nxt = n_r + (MAXP+1)'(1);
          pos_nxt = (pos_r + hstep) & mk;
          state_nxt = S_ADDR;
        end
        if (res_ld) state_nxt = S_DONE;
      end
      S_WRITE: begin
        ram_we = 1'b1;
        bump = 1'b1;
        res_ld = 1'b1;
        rst_st = mdht_pkg::ST_INSERTED;
        rfl = 3'(lv_r);
        state_nxt = S_DONE;
      end
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_IDLE && in_valid) begin
      if (key_zero || failed_r || (!in_op && in_sequence_req == '0)) begin
        res_ld = 1'b1;
        rst_st = key_zero ? mdht_pkg::ST_ZERO_KEY :
                 failed_r ? mdht_pkg::ST_FAILED : mdht_pkg::ST_BAD_SEQ;
        state_nxt = S_DONE;
      end else begin
        lv_nxt = '0;
        n_nxt = '0;
        pos_nxt = MAXP'({in_key_word1[7:0], in_key_word0[63:8]});
        state_nxt = S_ADDR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      sealed_r <= '0;
      failed_r <= 1'b0;
      limit_r <= '0;
      ov_r <= 1'b0;
      for (int i = 0; i < LEVELS; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      if (cfg_valid) limit_r <= cfg_visible_sequence_limit;
      if (set_fail) failed_r <= 1'b1;
      if (bump) begin
        cnt_r[lv_r] <= cnt_r[lv_r] + CW'(1);
        if (cnt_r[lv_r] + CW'(1) >= lthr(lv_r)) sealed_r[lv_r] <= 1'b1;
      end
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (state_r == S_DONE && out_free) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    lv_r <= lv_nxt;
    pos_r <= pos_nxt;
    n_r <= n_nxt;
    at_r <= at_nxt;
    if (state_r == S_IDLE && in_valid) begin
      key_r <= {in_key_word3, in_key_word2, in_key_word1, in_key_word0};
      seq_r <= in_sequence_req;
      pay_r <= in_payload;
      op_r <= in_op;
    end
    if (res_ld) begin
      pst_r <= rst_st;
      pfs_r <= rfs;
      pfp_r <= rfp;
      pfl_r <= rfl;
    end
    if (state_r == S_DONE && out_free) begin
      st_r <= pst_r;
      fs_r <= pfs_r;
      fp_r <= pfp_r;
      fl_r <= pfl_r;
    end
  end

  `CHK_IMPL(a_stall_busy, clk, rst_n, state_r != S_IDLE, in_stall)
  `CHK_NEXT(a_out_hold, clk, rst_n, ov_r && out_stall, ov_r && $stable(st_r))
  `CHK_IMPL(a_write_unsealed, clk, rst_n, state_r == S_WRITE, !sealed_r[lv_r])
endmodule
